FILE: sv/s2da_pkg.sv
// Shared types and constants for the signed integer to decimal ASCII block.
// No dependencies; used by the controller, the datapath and the top level.
package s2da_pkg;

    localparam int BIN_W      = 32;
    localparam int NUM_DIGITS = 10;
    localparam int BCD_W      = 4 * NUM_DIGITS;
    localparam int CNT_W      = 5;
    localparam int IDX_W      = 4;
    localparam int CHAR_W     = 7;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'd48;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 7'd45;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_PREP,
        S_SIGN,
        S_DIGIT
    } t_state;

    typedef struct packed {
        logic load;
        logic shift;
        logic set_first;
        logic dec_idx;
        logic sel_sign;
    } t_dp_cmd;

    typedef struct packed {
        logic conv_done;
        logic neg;
        logic idx_zero;
    } t_dp_status;

endpackage

FILE: sv/s2da_dp.sv
// Datapath: magnitude register, shift-and-add-3 BCD converter, digit pointer
// and character selection. Depends on s2da_pkg; driven by s2da_ctrl.
module s2da_dp import s2da_pkg::*; (
    input  logic                     i_clk,
    input  logic signed [BIN_W-1:0]  i_value,
    input  t_dp_cmd                  i_cmd,
    output t_dp_status               o_status,
    output logic        [CHAR_W-1:0] o_character,
    output logic                     o_last
);

    logic [BIN_W-1:0] r_bin, n_bin;
    logic [BCD_W-1:0] r_bcd, n_bcd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_neg, n_neg;
    logic [BCD_W-1:0] adj_bcd;
    logic [IDX_W-1:0] first_idx;
    logic [3:0]       cur_digit;

    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (r_bcd[4*i +: 4] >= 4'd5) begin
                adj_bcd[4*i +: 4] = r_bcd[4*i +: 4] + 4'd3;
            end else begin
                adj_bcd[4*i +: 4] = r_bcd[4*i +: 4];
            end
        end
    end

    always_comb begin
        first_idx = '0;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (r_bcd[4*i +: 4] != 4'd0) begin
                first_idx = IDX_W'(i);
            end
        end
    end

    always_comb begin
        n_bin = r_bin;
        n_bcd = r_bcd;
        n_cnt = r_cnt;
        n_idx = r_idx;
        n_neg = r_neg;
        if (i_cmd.load) begin
            n_neg = i_value[BIN_W-1];
            n_bin = i_value[BIN_W-1] ? ($unsigned(~i_value) + 1'b1) : $unsigned(i_value);
            n_bcd = '0;
            n_cnt = '0;
        end else if (i_cmd.shift) begin
            n_bcd = {adj_bcd[BCD_W-2:0], r_bin[BIN_W-1]};
            n_bin = {r_bin[BIN_W-2:0], 1'b0};
            n_cnt = r_cnt + 1'b1;
        end else if (i_cmd.set_first) begin
            n_idx = first_idx;
        end else if (i_cmd.dec_idx) begin
            n_idx = r_idx - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin <= n_bin;
        r_bcd <= n_bcd;
        r_cnt <= n_cnt;
        r_idx <= n_idx;
        r_neg <= n_neg;
    end

    assign cur_digit = r_bcd[{r_idx, 2'b00} +: 4];

    assign o_status.conv_done = (r_cnt == CNT_W'(BIN_W - 1));
    assign o_status.neg       = r_neg;
    assign o_status.idx_zero  = (r_idx == '0);

    assign o_character = i_cmd.sel_sign ? ASCII_MINUS : (ASCII_ZERO + CHAR_W'(cur_digit));
    assign o_last      = !i_cmd.sel_sign && (r_idx == '0);

endmodule

FILE: sv/s2da_ctrl.sv
// Controller state machine: load, 32 conversion steps, digit pointer setup,
// then one character per accepted output item. Depends on s2da_pkg.
module s2da_ctrl import s2da_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CONV;
                end
            end
            S_CONV: begin
                o_cmd.shift = 1'b1;
                if (i_status.conv_done) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.set_first = 1'b1;
                n_state = i_status.neg ? S_SIGN : S_DIGIT;
            end
            S_SIGN: begin
                o_out_valid    = 1'b1;
                o_cmd.sel_sign = 1'b1;
                if (i_out_ready) begin
                    n_state = S_DIGIT;
                end
            end
            S_DIGIT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (i_status.idx_zero) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.dec_idx = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_accept_starts_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_CONV))
        else $error("accepted item did not start conversion");

    a_last_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIGIT && i_out_ready && i_status.idx_zero) |=> (r_state == S_IDLE))
        else $error("final character did not return to idle");

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.load, o_cmd.shift, o_cmd.set_first, o_cmd.dec_idx}))
        else $error("more than one datapath command");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input taken while a character is pending");

endmodule

FILE: sv/signed_int_to_decimal_ascii.sv
// Top level: signed 32-bit integer to decimal ASCII characters.
// Depends on s2da_pkg, s2da_ctrl and s2da_dp.
//
// Input channel (i_in_valid / o_in_ready, i_value): one signed integer per item.
// Output channel (o_out_valid / i_out_ready, o_character, o_last): one ASCII
// character per item, most significant first; '-' leads a negative value,
// there are no leading zeros, and o_last marks the final digit.
// Zero gives the single character '0'; the most negative value gives
// "-2147483648".
// After an input item is accepted, the value is loaded and goes through 32
// shift-and-add-3 steps and one pointer setup before o_out_valid rises.
// Each number gives N = 1..11 characters.
// One number is handled at a time: o_in_ready is high only while idle.
// A stalled receiver holds the current character and flag steady until taken.
// Reset returns the block to idle and drops any number in progress.
module signed_int_to_decimal_ascii import s2da_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic signed [BIN_W-1:0] i_value,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic       [CHAR_W-1:0] o_character,
    output logic                    o_last
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    s2da_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (dp_status),
        .o_cmd       (dp_cmd)
    );

    s2da_dp u_dp (
        .i_clk       (i_clk),
        .i_value     (i_value),
        .i_cmd       (dp_cmd),
        .o_status    (dp_status),
        .o_character (o_character),
        .o_last      (o_last)
    );

endmodule
